### hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge, skip while in reset.
`define BBA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define BBA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/bba_pkg.sv
// Package: types, codes and defaults of the bitmap block allocator.
`default_nettype none
package bba_pkg;

    localparam int DEF_MAX_BLOCKS     = 4096;
    localparam int DEF_BITS_PER_CHUNK = 256;
    localparam int DEF_PENDING_DEPTH  = 64;

    localparam int RESERVED_BLOCKS = 2;
    localparam int WORD_W          = 32;
    localparam int BIT_W           = 5;
    localparam int TB_W            = 13;
    localparam int BLK_W           = 12;
    localparam int CNT_OUT_W       = 7;
    localparam int DIRTY_OUT_W     = 16;
    localparam int PADDR_W         = 3;

    localparam logic [2:0] MODE_INIT     = 3'd0;
    localparam logic [2:0] MODE_MARK     = 3'd1;
    localparam logic [2:0] MODE_ALLOC    = 3'd2;
    localparam logic [2:0] MODE_FREE     = 3'd3;
    localparam logic [2:0] MODE_COMMIT   = 3'd4;
    localparam logic [2:0] MODE_CLEAR    = 3'd5;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NO_SPACE = 2'd1;
    localparam logic [1:0] STAT_RANGE    = 2'd2;
    localparam logic [1:0] STAT_FULL     = 2'd3;

    typedef struct packed {
        logic [2:0]       mode;
        logic [BLK_W-1:0] block_number;
    } in_item_t;

    typedef struct packed {
        logic [1:0]             status;
        logic [BLK_W-1:0]       granted_block;
        logic [BLK_W-1:0]       free_count;
        logic [CNT_OUT_W-1:0]   released_count;
        logic [CNT_OUT_W-1:0]   pending_count;
        logic [DIRTY_OUT_W-1:0] dirty_chunks;
    } out_item_t;

    typedef struct packed {
        logic we;
        logic clear;
    } bm_ctl_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MU_WR,
        S_AL_RD,
        S_AL_CHK,
        S_CM_RDP,
        S_CM_RDB,
        S_CM_WR,
        S_DONE
    } state_t;

endpackage
`default_nettype wire

### hw/rtl/bba_bitmap.sv
// Bitmap word memory with per-word valid bits; invalid words read as zero.
`default_nettype none
module bba_bitmap #(
    parameter int NW   = 128,
    parameter int WA_W = 7
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  bba_pkg::bm_ctl_t     ctl,
    input  wire [WA_W-1:0]       waddr,
    input  wire [31:0]           wdata,
    input  wire [WA_W-1:0]       raddr,
    output logic [31:0]          rdata
);
    import bba_pkg::*;

    logic [WORD_W-1:0] mem [NW];
    logic [NW-1:0]     valid_reg;
    logic [WORD_W-1:0] rd_reg;
    logic              rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            rvalid_reg <= valid_reg[raddr];
            if (ctl.clear)
            begin
                valid_reg <= '0;
            end
            else if (ctl.we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
        end
    end

    assign rdata = rvalid_reg ? rd_reg : '0;

endmodule
`default_nettype wire

### hw/rtl/bba_pending.sv
// Deferred free list storage: one write port, one registered read port.
`default_nettype none
module bba_pending #(
    parameter int PD   = 64,
    parameter int PA_W = 6
) (
    input  wire                        clk,
    input  wire                        we,
    input  wire [PA_W-1:0]             waddr,
    input  wire [bba_pkg::BLK_W-1:0]   wdata,
    input  wire [PA_W-1:0]             raddr,
    output logic [bba_pkg::BLK_W-1:0]  rdata
);
    import bba_pkg::*;

    logic [BLK_W-1:0] mem [PD];
    logic [BLK_W-1:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

    assign rdata = rd_reg;

endmodule
`default_nettype wire

### hw/rtl/bitmap_block_allocator_deferred_free.sv
// Top level: next-fit bitmap block allocator with deferred frees.
//
// Input channel in_valid/in_ready/in_data carries one command (mode, block_number);
// output channel out_valid/out_ready/out_data returns exactly one result per command.
// The block-count register is written through the APB port at byte address 0; the user
// must write it only while idle, and the block does not enforce this. The sequencer takes
// one command at a time; in_ready is high only when it is idle. Per command, acceptance
// to result in the output register: init, free_deferred, clear_dirty and unused modes go
// straight to the result; mark_used reads the bitmap word, then sets the bit if clear;
// allocate reads and searches one bitmap word at a time through the single bitmap read
// port and the 32-bit free-bit search, wrapping once to the blocks below the hint;
// commit_release reads each queued entry from the list, then its bitmap word, then writes it.
// A finished result waits in the output register; the next command is accepted
// meanwhile, and the sequencer holds its next result until out_ready frees the register.
// Reset clears the bitmap valid bits, chunk marks and list fill, sets the free
// count to the block count minus two and the hint to two; no clearing pass is needed.
`default_nettype none
`include "assert_macros.svh"
module bitmap_block_allocator_deferred_free #(
    parameter int MAX_BLOCKS     = bba_pkg::DEF_MAX_BLOCKS,
    parameter int BITS_PER_CHUNK = bba_pkg::DEF_BITS_PER_CHUNK,
    parameter int PENDING_DEPTH  = bba_pkg::DEF_PENDING_DEPTH
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  bba_pkg::in_item_t            in_data,
    output logic                         out_valid,
    input  wire                          out_ready,
    output bba_pkg::out_item_t           out_data,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [bba_pkg::PADDR_W-1:0]   paddr,
    input  wire [31:0]                   pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import bba_pkg::*;

    localparam int NW         = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int WA_W       = $clog2(NW);
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
    localparam int POS_W      = CNT_W + 1;
    localparam int FT_W       = CNT_W + 1;
    localparam int NUM_CHUNKS = (MAX_BLOCKS + BITS_PER_CHUNK - 1) / BITS_PER_CHUNK;
    localparam int CH_W       = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
    localparam int PA_W       = $clog2(PENDING_DEPTH);
    localparam int PF_W       = $clog2(PENDING_DEPTH + 1);
    localparam int RESET_EFF  = (MAX_BLOCKS < 4096) ? MAX_BLOCKS : 4096;
    localparam logic REG_DEV_BLOCKS = 1'b0;

    // Configuration register
    logic [TB_W-1:0] tb_reg;
    logic            cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_DEV_BLOCKS);
    assign prdata = (paddr[2] == REG_DEV_BLOCKS) ? 32'(tb_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tb_reg <= TB_W'(4096);
        end
        else if (cfg_wr)
        begin
            tb_reg <= pwdata[TB_W-1:0];
        end
    end

    // Effective total, clamped to 3..MAX_BLOCKS
    logic [31:0]      tb32;
    logic [CNT_W-1:0] eff_total;

    assign tb32 = 32'(tb_reg);
    always_comb
    begin
        if (tb32 < 32'd3)
        begin
            eff_total = CNT_W'(3);
        end
        else if (tb32 > 32'(MAX_BLOCKS))
        begin
            eff_total = CNT_W'(MAX_BLOCKS);
        end
        else
        begin
            eff_total = CNT_W'(tb32);
        end
    end

    // Sequencer and datapath registers
    state_t            state_reg, state_next;
    logic [BLK_W-1:0]  blk_reg, blk_next;
    logic [CNT_W-1:0]  tot_reg, tot_next;
    logic [POS_W-1:0]  lo_reg, lo_next;
    logic [POS_W-1:0]  hi_reg, hi_next;
    logic [POS_W-1:0]  start_reg, start_next;
    logic [WA_W-1:0]   word_reg, word_next;
    logic [WA_W-1:0]   endw_reg, endw_next;
    logic              seg_reg, seg_next;
    logic [PF_W-1:0]   idx_reg, idx_next;
    logic [1:0]        status_reg, status_next;
    logic [BLK_W-1:0]  grant_reg, grant_next;
    logic [PF_W-1:0]   rel_reg, rel_next;
    logic [FT_W-1:0]   ft_reg, ft_next;
    logic [POS_W-1:0]  hint_reg, hint_next;
    logic [PF_W-1:0]   fill_reg, fill_next;
    logic [NUM_CHUNKS-1:0] dirty_reg, dirty_next;
    logic              ovalid_reg, ovalid_next;
    out_item_t         odata_reg, odata_next;

    // Memory ports
    bm_ctl_t           bm_ctl;
    logic [WA_W-1:0]   bm_waddr, bm_raddr;
    logic [31:0]       bm_wdata, bm_rdata;
    logic              pd_we;
    logic [PA_W-1:0]   pd_waddr, pd_raddr;
    logic [BLK_W-1:0]  pd_wdata, pd_rdata;

    bba_bitmap #(
        .NW   (NW),
        .WA_W (WA_W)
    ) u_bitmap (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (bm_ctl),
        .waddr (bm_waddr),
        .wdata (bm_wdata),
        .raddr (bm_raddr),
        .rdata (bm_rdata)
    );

    bba_pending #(
        .PD   (PENDING_DEPTH),
        .PA_W (PA_W)
    ) u_pending (
        .clk   (clk),
        .we    (pd_we),
        .waddr (pd_waddr),
        .wdata (pd_wdata),
        .raddr (pd_raddr),
        .rdata (pd_rdata)
    );

    // Free-bit search over the current bitmap word
    logic [31:0]      scan_mask;
    logic [31:0]      scan_free;
    logic             scan_hit;
    logic [BIT_W-1:0] scan_bit;
    logic [31:0]      scan_pos;

    always_comb
    begin
        logic [31:0] p;
        scan_hit = 1'b0;
        scan_bit = '0;
        for (int j = 0; j < WORD_W; j++)
        begin
            p = 32'({word_reg, BIT_W'(j)});
            scan_mask[j] = (p >= 32'(lo_reg)) && (p < 32'(hi_reg));
        end
        scan_free = ~bm_rdata & scan_mask;
        for (int j = WORD_W - 1; j >= 0; j--)
        begin
            if (scan_free[j])
            begin
                scan_hit = 1'b1;
                scan_bit = BIT_W'(j);
            end
        end
        scan_pos = 32'({word_reg, scan_bit});
    end

    // Saturated and packed result fields
    logic [DIRTY_OUT_W-1:0] dirty_out;

    always_comb
    begin
        dirty_out = '0;
        for (int c = 0; c < NUM_CHUNKS && c < DIRTY_OUT_W; c++)
        begin
            dirty_out[c] = dirty_reg[c];
        end
    end

    always_comb
    begin
        logic [31:0] blk32;
        logic [31:0] start32;
        logic        cm_ok;
        state_next  = state_reg;
        blk_next    = blk_reg;
        tot_next    = tot_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        start_next  = start_reg;
        word_next   = word_reg;
        endw_next   = endw_reg;
        seg_next    = seg_reg;
        idx_next    = idx_reg;
        status_next = status_reg;
        grant_next  = grant_reg;
        rel_next    = rel_reg;
        ft_next     = ft_reg;
        hint_next   = hint_reg;
        fill_next   = fill_reg;
        dirty_next  = dirty_reg;
        ovalid_next = ovalid_reg;
        odata_next  = odata_reg;
        bm_ctl      = '0;
        bm_waddr    = word_reg;
        bm_wdata    = bm_rdata;
        bm_raddr    = word_reg;
        pd_we       = 1'b0;
        pd_waddr    = fill_reg[PA_W-1:0];
        pd_wdata    = in_data.block_number;
        pd_raddr    = idx_reg[PA_W-1:0];
        in_ready    = (state_reg == S_IDLE);
        blk32       = 32'(in_data.block_number);
        start32     = '0;
        cm_ok       = 1'b0;

        // Drop the delivered result
        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                bm_raddr = WA_W'(blk32 >> BIT_W);
                if (in_valid)
                begin
                    blk_next    = in_data.block_number;
                    tot_next    = eff_total;
                    status_next = STAT_OK;
                    grant_next  = '0;
                    rel_next    = '0;
                    state_next  = S_DONE;
                    case (in_data.mode)
                        MODE_INIT:
                        begin
                            bm_ctl.clear = 1'b1;
                            dirty_next   = '0;
                            ft_next      = FT_W'(eff_total) - FT_W'(RESERVED_BLOCKS);
                            hint_next    = POS_W'(RESERVED_BLOCKS);
                            fill_next    = '0;
                        end
                        MODE_MARK:
                        begin
                            if (blk32 >= 32'(eff_total))
                            begin
                                status_next = STAT_RANGE;
                            end
                            else
                            begin
                                state_next = S_MU_WR;
                            end
                        end
                        MODE_ALLOC:
                        begin
                            if (ft_reg == '0)
                            begin
                                status_next = STAT_NO_SPACE;
                            end
                            else
                            begin
                                start32    = (32'(hint_reg) < 32'(eff_total)) ?
                                             32'(hint_reg) : 32'(RESERVED_BLOCKS);
                                start_next = POS_W'(start32);
                                lo_next    = POS_W'(start32);
                                hi_next    = POS_W'(eff_total);
                                seg_next   = 1'b0;
                                word_next  = WA_W'(start32 >> BIT_W);
                                endw_next  = WA_W'((32'(eff_total) - 32'd1) >> BIT_W);
                                state_next = S_AL_RD;
                            end
                        end
                        MODE_FREE:
                        begin
                            if (blk32 < 32'(RESERVED_BLOCKS) || blk32 >= 32'(eff_total))
                            begin
                                status_next = STAT_RANGE;
                            end
                            else if (32'(fill_reg) >= 32'(PENDING_DEPTH))
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                pd_we     = 1'b1;
                                fill_next = fill_reg + PF_W'(1);
                            end
                        end
                        MODE_COMMIT:
                        begin
                            idx_next = '0;
                            if (fill_reg != '0)
                            begin
                                state_next = S_CM_RDP;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            dirty_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_MU_WR:
            begin
                if (!bm_rdata[blk_reg[BIT_W-1:0]])
                begin
                    bm_ctl.we = 1'b1;
                    bm_waddr  = WA_W'(32'(blk_reg) >> BIT_W);
                    bm_wdata  = bm_rdata | (32'd1 << blk_reg[BIT_W-1:0]);
                    if (32'(blk_reg) >= 32'(RESERVED_BLOCKS) && ft_reg != '0)
                    begin
                        ft_next = ft_reg - FT_W'(1);
                    end
                end
                state_next = S_DONE;
            end

            S_AL_RD:
            begin
                state_next = S_AL_CHK;
            end

            S_AL_CHK:
            begin
                if (scan_hit)
                begin
                    bm_ctl.we  = 1'b1;
                    bm_wdata   = bm_rdata | (32'd1 << scan_bit);
                    dirty_next[CH_W'(scan_pos / BITS_PER_CHUNK)] = 1'b1;
                    ft_next    = ft_reg - FT_W'(1);
                    hint_next  = POS_W'(scan_pos + 32'd1);
                    grant_next = BLK_W'(scan_pos);
                    state_next = S_DONE;
                end
                else if (word_reg == endw_reg)
                begin
                    // Wrap to the blocks below the starting hint
                    if (!seg_reg && 32'(start_reg) > 32'(RESERVED_BLOCKS))
                    begin
                        seg_next   = 1'b1;
                        lo_next    = POS_W'(RESERVED_BLOCKS);
                        hi_next    = start_reg;
                        word_next  = '0;
                        endw_next  = WA_W'((32'(start_reg) - 32'd1) >> BIT_W);
                        state_next = S_AL_RD;
                    end
                    else
                    begin
                        status_next = STAT_NO_SPACE;
                        state_next  = S_DONE;
                    end
                end
                else
                begin
                    word_next  = word_reg + WA_W'(1);
                    state_next = S_AL_RD;
                end
            end

            S_CM_RDP:
            begin
                state_next = S_CM_RDB;
            end

            S_CM_RDB:
            begin
                blk_next   = pd_rdata;
                bm_raddr   = WA_W'(32'(pd_rdata) >> BIT_W);
                state_next = S_CM_WR;
            end

            S_CM_WR:
            begin
                cm_ok = (32'(blk_reg) >= 32'(RESERVED_BLOCKS)) &&
                        (32'(blk_reg) < 32'(tot_reg)) &&
                        bm_rdata[blk_reg[BIT_W-1:0]];
                if (cm_ok)
                begin
                    bm_ctl.we = 1'b1;
                    bm_waddr  = WA_W'(32'(blk_reg) >> BIT_W);
                    bm_wdata  = bm_rdata & ~(32'd1 << blk_reg[BIT_W-1:0]);
                    dirty_next[CH_W'(32'(blk_reg) / BITS_PER_CHUNK)] = 1'b1;
                    ft_next   = ft_reg + FT_W'(1);
                    rel_next  = rel_reg + PF_W'(1);
                end
                if (idx_reg + PF_W'(1) >= fill_reg)
                begin
                    fill_next  = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + PF_W'(1);
                    state_next = S_CM_RDP;
                end
            end

            S_DONE:
            begin
                // Hold the result until the output register is free
                if (!ovalid_reg || out_ready)
                begin
                    ovalid_next              = 1'b1;
                    odata_next.status        = status_reg;
                    odata_next.granted_block = grant_reg;
                    odata_next.free_count    = (32'(ft_reg) > 32'd4095) ?
                                               BLK_W'(4095) : BLK_W'(ft_reg);
                    odata_next.released_count = (32'(rel_reg) > 32'd127) ?
                                                CNT_OUT_W'(127) : CNT_OUT_W'(rel_reg);
                    odata_next.pending_count = (32'(fill_reg) > 32'd127) ?
                                               CNT_OUT_W'(127) : CNT_OUT_W'(fill_reg);
                    odata_next.dirty_chunks  = dirty_out;
                    state_next               = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
            ft_reg     <= FT_W'(RESET_EFF - RESERVED_BLOCKS);
            hint_reg   <= POS_W'(RESERVED_BLOCKS);
            fill_reg   <= '0;
            dirty_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            ft_reg     <= ft_next;
            hint_reg   <= hint_next;
            fill_reg   <= fill_next;
            dirty_reg  <= dirty_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg    <= blk_next;
        tot_reg    <= tot_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        start_reg  <= start_next;
        word_reg   <= word_next;
        endw_reg   <= endw_next;
        seg_reg    <= seg_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
        grant_reg  <= grant_next;
        rel_reg    <= rel_next;
        odata_reg  <= odata_next;
    end

    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;

    `BBA_ASSERT(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready, "ready after accept")
    `BBA_ASSERT(a_fill_bound, 32'(fill_reg) <= 32'(PENDING_DEPTH), "list overfilled")
    `BBA_ASSERT(a_grant_reserved, (out_valid && out_data.granted_block != '0) |-> (out_data.granted_block >= BLK_W'(RESERVED_BLOCKS) && out_data.status == STAT_OK), "reserved block granted")

endmodule
`default_nettype wire
